/* hw/rtl/sha512_pkg.sv */
`timescale 1ns / 1ps
package sha512_pkg;

  localparam int DIGEST_WORDS = 8;
  localparam int ROUNDS = 80;
  localparam int BLOCK_WORDS = 16;
  localparam int CFG_REGS = 8;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic [63:0] message_word;
    logic        start_message;
    logic        final_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_item_t;

  // Front to back: one classified word
  typedef struct packed {
    logic [63:0] sched_word;
    logic        start;
    logic        last_slot;
    logic        final_block;
  } fq_item_t;

  typedef logic [63:0] kround_arr_t [ROUNDS];

  localparam kround_arr_t KROUND = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
    rotr64 = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] bswap64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = x[8*(7-i) +: 8];
    bswap64 = r;
  endfunction

  function automatic logic [63:0] big0(input logic [63:0] x);
    big0 = rotr64(x, 28) ^ rotr64(x, 34) ^ rotr64(x, 39);
  endfunction
  function automatic logic [63:0] big1(input logic [63:0] x);
    big1 = rotr64(x, 14) ^ rotr64(x, 18) ^ rotr64(x, 41);
  endfunction
  function automatic logic [63:0] small0(input logic [63:0] x);
    small0 = rotr64(x, 1) ^ rotr64(x, 8) ^ (x >> 7);
  endfunction
  function automatic logic [63:0] small1(input logic [63:0] x);
    small1 = rotr64(x, 19) ^ rotr64(x, 61) ^ (x >> 6);
  endfunction

endpackage

/* hw/rtl/sha512_front.sv */
`timescale 1ns / 1ps
module sha512_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha512_pkg::in_item_t  in_data,
  output logic                  fq_valid,
  input  logic                  fq_ready,
  output sha512_pkg::fq_item_t  fq_data
);
  import sha512_pkg::*;

  localparam int QD = 2;

  fq_item_t   q_r [QD];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic [3:0] word_count_r, word_count_nxt;
  logic       push, pop;
  fq_item_t   cls;

  assign in_ready = (cnt_r != 2'(QD));
  assign push = in_valid && in_ready;
  assign fq_valid = (cnt_r != 2'd0);
  assign pop = fq_valid && fq_ready;
  assign fq_data = q_r[rp_r];

  always_comb begin
    cls.sched_word  = bswap64(in_data.message_word);
    cls.start       = in_data.start_message;
    cls.last_slot   = (word_count_r == 4'(BLOCK_WORDS - 1));
    cls.final_block = in_data.final_block;
    word_count_nxt  = push ? word_count_r + 4'd1 : word_count_r;
    cnt_nxt         = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      word_count_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      word_count_r <= word_count_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

endmodule

/* hw/rtl/sha512_back.sv */
`timescale 1ns / 1ps
module sha512_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fq_valid,
  output logic                             fq_ready,
  input  sha512_pkg::fq_item_t             fq_data,
  input  logic                             cfg_we,
  input  logic [sha512_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [63:0]                      cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sha512_pkg::out_item_t            out_data
);
  import sha512_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] init_r [CFG_REGS];
  logic [63:0] hash_r [8];
  logic [63:0] v_r [8];
  logic [63:0] w_r [BLOCK_WORDS];
  logic [3:0]  wp_r;
  logic [6:0]  round_r;
  logic        final_r;
  logic [2:0]  emit_r;
  logic        ov_r;
  out_item_t   od_r;
  logic [63:0] wt, wnew, t1, t2;
  logic        take;

  assign fq_ready = (state_r == ST_IDLE);
  assign take = fq_valid && fq_ready;
  assign out_valid = ov_r;
  assign out_data = od_r;

  // window as a shift line: w_r[0] is w[t]
  always_comb begin
    wt = w_r[0];
    wnew = small1(w_r[14]) + w_r[9] + small0(w_r[1]) + w_r[0];
    t1 = v_r[7] + big1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + KROUND[round_r] + wt;
    t2 = big0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (take && fq_data.last_slot) state_nxt = ST_ROUND;
      ST_ROUND: if (round_r == 7'(ROUNDS - 1)) state_nxt = ST_ADD;
      ST_ADD:   state_nxt = final_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if ((!ov_r || out_ready) && emit_r == 3'(DIGEST_WORDS - 1))
                  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
      emit_r <= '0;
      ov_r <= 1'b0;
      wp_r <= '0;
      final_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        init_r[i] <= '0;
        hash_r[i] <= '0;
        v_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) init_r[cfg_idx] <= cfg_data;
      // drop valid once taken, unless the next digest word replaces it
      if (ov_r && out_ready && state_r != ST_EMIT) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (take) begin
            if (fq_data.start)
              for (int i = 0; i < 8; i++) hash_r[i] <= init_r[i];
            w_r[wp_r] <= fq_data.sched_word;
            wp_r <= wp_r + 4'd1;
            final_r <= fq_data.final_block;
            if (fq_data.last_slot) begin
              for (int i = 0; i < 8; i++) v_r[i] <= fq_data.start ? init_r[i] : hash_r[i];
              round_r <= '0;
            end
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < BLOCK_WORDS - 1; i++) w_r[i] <= w_r[i+1];
          w_r[BLOCK_WORDS-1] <= wnew;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          round_r <= round_r + 7'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
          round_r <= '0;
          emit_r <= '0;
          wp_r <= '0;
        end
        ST_EMIT: begin
          if (!ov_r || out_ready) begin
            ov_r <= 1'b1;
            od_r.digest_word <= hash_r[emit_r];
            od_r.digest_index <= emit_r;
            od_r.digest_last <= (emit_r == 3'(DIGEST_WORDS - 1));
            emit_r <= emit_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/sha512_block_compress.sv */
`timescale 1ns / 1ps
// SHA-512 block compression, word-serial.
// Input channel (in_valid/in_ready/in_data): one 64-bit message word per
// request, bytes in memory order; start_message reloads the chaining hash
// from the eight cfg registers, final_block is read on the 16th word.
// Output channel (out_valid/out_ready/out_data): after a final block,
// DIGEST_WORDS chaining words in index order, digest_last on the last.
// Config: cfg_we/cfg_idx/cfg_data write initial_hash_N, index above 7
// ignored; write only while idle.
// Flow: words 1..15 of a block pass through a two-entry queue; the 16th
// word starts 80 rounds at one per cycle (one shared round unit), then
// an add step. A final block then emits DIGEST_WORDS output words.
// The queue holds up to two words while the core is busy.
// Reset clears counters, hash and config registers. A stalled receiver
// holds the digest register; the queue then fills and in_ready drops.
module sha512_block_compress (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha512_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha512_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_idx,
  input  logic [63:0]           cfg_data
);
  import sha512_pkg::*;

  logic     fq_valid, fq_ready;
  fq_item_t fq_data;

  sha512_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .fq_valid, .fq_ready, .fq_data
  );

  sha512_back u_back (
    .clk, .rst_n, .fq_valid, .fq_ready, .fq_data,
    .cfg_we(cfg_we && !cfg_idx[3]), .cfg_idx(cfg_idx[2:0]), .cfg_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

/* hw/rtl/sha512_checker.sv */
`timescale 1ns / 1ps
module sha512_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sha512_pkg::out_item_t out_data
);
  import sha512_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input request dropped before accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output not held under stall");

  a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.digest_last |=> ##0
    (!out_valid || out_data.digest_index == $past(out_data.digest_index) + 3'd1))
    else $error("digest index out of order");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.digest_last |->
    out_data.digest_index == 3'(DIGEST_WORDS - 1))
    else $error("last flag on wrong index");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sha512_block_compress sha512_checker u_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

/* tb/tb_sha512_block_compress.sv */
`timescale 1ns / 1ps
module tb_sha512_block_compress;
  import sha512_pkg::*;

  localparam logic [3:0] IDX_BAD = 4'd12;

  class digest_scoreboard;
    logic [63:0] init_hash [8];
    logic [63:0] chain [8];
    logic [63:0] window [16];
    int unsigned slot;
    out_item_t pending [$];
    int errors;
    int checked;
    int blocks;

    function new();
      foreach (init_hash[i]) init_hash[i] = '0;
      foreach (chain[i]) chain[i] = '0;
      foreach (window[i]) window[i] = '0;
      slot = 0;
      errors = 0;
      checked = 0;
      blocks = 0;
    endfunction

    function automatic logic [63:0] ror(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function void compress_block();
      logic [63:0] w [80];
      logic [63:0] v [8];
      logic [63:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) w[t] = window[t];
      for (int t = 16; t < 80; t++) begin
        s0 = ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7);
        s1 = ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      foreach (v[i]) v[i] = chain[i];
      for (int t = 0; t < 80; t++) begin
        t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KROUND[t] + w[t];
        t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] = chain[i] + v[i];
      blocks++;
    endfunction

    function void write_reg(logic [3:0] idx, logic [63:0] val);
      if (idx < 8) init_hash[idx[2:0]] = val;
    endfunction

    function void note_request(in_item_t req);
      out_item_t r;
      logic [63:0] sw;
      if (req.start_message) foreach (chain[i]) chain[i] = init_hash[i];
      for (int b = 0; b < 8; b++) sw[8*b +: 8] = req.message_word[8*(7-b) +: 8];
      window[slot] = sw;
      if (slot == 15) begin
        compress_block();
        if (req.final_block)
          for (int i = 0; i < DIGEST_WORDS; i++) begin
            r.digest_word = chain[i];
            r.digest_index = i[2:0];
            r.digest_last = (i == DIGEST_WORDS - 1);
            pending.push_back(r);
          end
      end
      slot = (slot + 1) % 16;
    endfunction

    function void check_digest(out_item_t got);
      out_item_t exp_item;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected digest word", got, got);
        return;
      end
      exp_item = pending.pop_front();
      if (got.digest_word !== exp_item.digest_word) report("digest_word", got, exp_item);
      if (got.digest_index !== exp_item.digest_index) report("digest_index", got, exp_item);
      if (got.digest_last !== exp_item.digest_last) report("digest_last", got, exp_item);
    endfunction

    function void report(string what, out_item_t got, out_item_t want);
      errors++;
      $display("mismatch %s: got %h/%0d/%b want %h/%0d/%b", what, got.digest_word,
               got.digest_index, got.digest_last, want.digest_word, want.digest_index,
               want.digest_last);
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_we;
  logic [3:0] cfg_idx;
  logic [63:0] cfg_data;

  digest_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int words_sent;

  sha512_block_compress i_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  // receiver: stall at random, check every accepted digest word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_digest(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hold the request until the edge that accepts it
  task automatic send_word(logic [63:0] w, logic st, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{message_word: w, start_message: st, final_block: fin};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sb.note_request(in_data);
    words_sent++;
  endtask

  task automatic write_cfg(logic [3:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // let the block finish any compress that yields nothing, and drain
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // nblk blocks: word 0 starts if with_start, final on the last block
  task automatic send_message(int nblk, bit with_start, bit noise);
    logic st, fin;
    for (int b = 0; b < nblk; b++)
      for (int w = 0; w < 16; w++) begin
        st = (with_start && b == 0 && w == 0);
        fin = (b == nblk - 1);
        if (noise && w != 15) begin
          if ($urandom_range(9) == 0) st = 1'b1;
          fin = 1'($urandom_range(1));
        end
        send_word(rand64(), st, fin);
      end
  endtask

  task automatic set_regs(int mode);
    wait_idle();
    for (int i = 0; i < 8; i++)
      write_cfg(i[3:0], mode == 0 ? 64'h0 : mode == 1 ? '1 : rand64());
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    words_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset-zero hash, all-ones words, then extremes of config
    for (int w = 0; w < 16; w++) send_word('1, w == 0, w == 15);
    wait_idle();
    set_regs(1);
    write_cfg(IDX_BAD, 64'hdead_beef_0000_0001);
    // start mid-block, final flag on non-last words ignored
    for (int w = 0; w < 16; w++) send_word(64'h0, w == 0 || w == 7, w != 15 || 1'b1);
    wait_idle();
    // no start after a final block: continue chaining
    send_message(1, 0, 0);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      set_regs(phase == 0 ? 0 : 2);
      send_message(1, 1, 0);
      // register write between messages takes effect only at next start
      wait_idle();
      write_cfg(4'($urandom_range(7)), rand64());
      send_message(1, 1, 1);
      send_message(1, 1'($urandom_range(1)), 0);
      if (phase == 1) wait_idle();
    end

    wait_idle();
    $display("covered %0d message words, %0d blocks, %0d digest words checked",
             words_sent, sb.blocks, sb.checked);
    $display("idle and stall mixes: none, sender 85%%, receiver 85%%, both 26%%");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
